// ----- design/espp_pkg.sv -----
package espp_pkg;

    localparam int DEF_MAX_SEQ_CHARS = 16;
    localparam int DEF_PARAM_SLOTS   = 3;
    localparam int DEF_QUEUE_DEPTH   = 2;

    localparam logic [7:0] CH_VSYNC = 8'hFE;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [7:0] LT_VERSION   = 8'h76; // 'v'
    localparam logic [7:0] LT_M_PRESS   = 8'h42; // 'B'
    localparam logic [7:0] LT_M_RELEASE = 8'h52; // 'R'
    localparam logic [7:0] LT_M_MOVE    = 8'h4D; // 'M'
    localparam logic [7:0] LT_J_PRESS   = 8'h4A; // 'J'
    localparam logic [7:0] LT_J_RELEASE = 8'h4B; // 'K'
    localparam logic [7:0] LT_COLLISION = 8'h63; // 'c'

    localparam logic [15:0] DEC_RADIX = 16'd10;

    typedef enum logic [3:0] {
        EV_VSYNC     = 4'd0,
        EV_KEY       = 4'd1,
        EV_VERSION   = 4'd2,
        EV_M_PRESS   = 4'd3,
        EV_M_RELEASE = 4'd4,
        EV_M_MOVE    = 4'd5,
        EV_J_PRESS   = 4'd6,
        EV_J_RELEASE = 4'd7,
        EV_COLLISION = 4'd8,
        EV_INVALID   = 4'd9
    } t_event_kind;

    typedef enum logic [2:0] {
        CLS_VSYNC,
        CLS_ESC,
        CLS_HASH,
        CLS_SEMI,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        t_event_kind kind;
        logic [7:0]  data;
    } t_token;

    typedef struct packed {
        t_event_kind        kind;
        logic [7:0]         key_code;
        logic signed [15:0] field_a;
        logic signed [15:0] field_b;
        logic signed [15:0] field_c;
        logic               separation;
    } t_event;

endpackage

// ----- design/espp_front.sv -----
module espp_front (
    input  logic [7:0]      i_byte,
    output espp_pkg::t_token o_tok
);
    import espp_pkg::*;

    t_cls        cls;
    t_event_kind kind;

    always_comb begin
        priority if (i_byte == CH_VSYNC) begin
            cls = CLS_VSYNC;
        end else if (i_byte == CH_ESC) begin
            cls = CLS_ESC;
        end else if (i_byte == CH_HASH) begin
            cls = CLS_HASH;
        end else if (i_byte == CH_SEMI) begin
            cls = CLS_SEMI;
        end else if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else if ((i_byte >= CH_UP_A && i_byte <= CH_UP_Z) ||
                     (i_byte >= CH_LO_A && i_byte <= CH_LO_Z)) begin
            cls = CLS_LETTER;
        end else begin
            cls = CLS_OTHER;
        end
    end

    // letter decode; only meaningful when cls is CLS_LETTER
    always_comb begin
        unique case (i_byte)
            LT_VERSION:   kind = EV_VERSION;
            LT_M_PRESS:   kind = EV_M_PRESS;
            LT_M_RELEASE: kind = EV_M_RELEASE;
            LT_M_MOVE:    kind = EV_M_MOVE;
            LT_J_PRESS:   kind = EV_J_PRESS;
            LT_J_RELEASE: kind = EV_J_RELEASE;
            LT_COLLISION: kind = EV_COLLISION;
            default:      kind = EV_INVALID;
        endcase
    end

    assign o_tok = '{cls: cls, kind: kind, data: i_byte};

endmodule

// ----- design/espp_queue.sv -----
module espp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/espp_back.sv -----
module espp_back #(
    parameter int MAX_SEQ_CHARS = espp_pkg::DEF_MAX_SEQ_CHARS,
    parameter int PARAM_SLOTS   = espp_pkg::DEF_PARAM_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  espp_pkg::t_token i_tok,
    output logic             o_tok_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output espp_pkg::t_event o_evt
);
    import espp_pkg::*;

    localparam int CW = $clog2(MAX_SEQ_CHARS + 1);
    localparam int IW = $clog2(PARAM_SLOTS + 1);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_SEQ_CHARS);
    localparam logic [IW-1:0] SLOTS_C = IW'(PARAM_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_PARAMS
    } t_mode;

    t_mode         r_mode, n_mode;
    logic [15:0]   r_acc, n_acc;
    logic [15:0]   r_slot [PARAM_SLOTS];
    logic [15:0]   n_slot [PARAM_SLOTS];
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    t_event        r_evt, n_evt;

    logic          pop;
    logic [3:0]    digit;
    logic [15:0]   p0, p1, p2;

    assign pop   = i_tok_valid && (!r_out_valid || i_out_ready);
    assign digit = 4'(i_tok.data - CH_ZERO);

    // parameters as seen by a terminating letter: the pending value lands first
    assign p0 = (r_idx == IW'(0)) ? r_acc : r_slot[0];
    assign p1 = (r_idx == IW'(1)) ? r_acc : r_slot[1];
    assign p2 = (r_idx == IW'(2)) ? r_acc : r_slot[2];

    always_comb begin
        n_mode      = r_mode;
        n_acc       = r_acc;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_evt       = r_evt;
        if (pop) begin
            unique case (r_mode)
                ST_HASH: begin
                    if (i_tok.cls == CLS_HASH) begin
                        n_mode = ST_PARAMS;
                        n_acc  = '0;
                        n_idx  = '0;
                        n_cnt  = '0;
                        for (int k = 0; k < PARAM_SLOTS; k++) begin
                            n_slot[k] = '0;
                        end
                    end else begin
                        n_mode = ST_IDLE;
                    end
                end
                ST_PARAMS: begin
                    if (r_cnt >= MAX_C) begin
                        n_mode = ST_IDLE;   // overlong sequence, dropped
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                        unique case (i_tok.cls)
                            CLS_SEMI: begin
                                for (int k = 0; k < PARAM_SLOTS; k++) begin
                                    if (r_idx == IW'(k)) begin
                                        n_slot[k] = r_acc;
                                    end
                                end
                                if (r_idx < SLOTS_C) begin
                                    n_idx = r_idx + IW'(1);
                                end
                                n_acc = '0;
                            end
                            CLS_DIGIT: begin
                                n_acc = r_acc * DEC_RADIX + 16'(digit);
                            end
                            CLS_LETTER: begin
                                n_mode      = ST_IDLE;
                                n_out_valid = 1'b1;
                                n_evt       = '0;
                                n_evt.kind  = i_tok.kind;
                                unique case (i_tok.kind)
                                    EV_VERSION, EV_M_PRESS, EV_M_RELEASE, EV_M_MOVE: begin
                                        n_evt.field_a = p0;
                                        n_evt.field_b = p1;
                                        n_evt.field_c = p2;
                                    end
                                    EV_J_PRESS, EV_J_RELEASE: begin
                                        n_evt.field_a = p0;
                                    end
                                    EV_COLLISION: begin
                                        n_evt.field_b    = p1;
                                        n_evt.field_c    = p2;
                                        n_evt.separation = (p0 != '0);
                                    end
                                    default: begin
                                        n_evt.kind = EV_INVALID;
                                    end
                                endcase
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    n_mode = ST_IDLE;
                    if (i_tok.cls == CLS_VSYNC) begin
                        n_out_valid = 1'b1;
                        n_evt       = '0;
                        n_evt.kind  = EV_VSYNC;
                    end else if (i_tok.cls == CLS_ESC) begin
                        n_mode = ST_HASH;
                    end else begin
                        n_out_valid    = 1'b1;
                        n_evt          = '0;
                        n_evt.kind     = EV_KEY;
                        n_evt.key_code = i_tok.data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_IDLE;
            r_acc       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < PARAM_SLOTS; k++) begin
                r_slot[k] <= '0;
            end
        end else begin
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_slot      <= n_slot;
        end
        r_evt <= n_evt;
    end

    assign o_tok_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_evt       = r_evt;

endmodule

// ----- design/escape_sequence_event_parser_top.sv -----
// Terminal escape-sequence event parser.
// Input channel (i_in_valid / o_in_ready / i_byte_in): one received byte per
// transfer. Output channel (o_out_valid / i_out_ready / event fields): at most
// one event per byte. Plain bytes give key events, 0xFE gives vsync, and
// ESC '#' <params> <letter> gives a decoded event.
// A classifier pushes tagged bytes into a QUEUE_DEPTH-entry queue; the parser
// pops one per cycle, while its single output register is free or being taken.
// Throughput: one byte per cycle while i_out_ready stays high, set by the
// parser's per-byte state update and the output register, which reloads in
// the cycle it is taken. With an empty queue, a byte's event passes through
// the queue entry and then the output register before o_out_valid rises.
// When the receiver stalls, the held event stays put and the queue absorbs up
// to QUEUE_DEPTH more bytes; o_in_ready drops once it is full.
// Reset (synchronous, active low) empties the queue, drops any held event and
// returns the parser to idle with cleared parameters.
module escape_sequence_event_parser_top #(
    parameter int MAX_SEQ_CHARS = espp_pkg::DEF_MAX_SEQ_CHARS,
    parameter int PARAM_SLOTS   = espp_pkg::DEF_PARAM_SLOTS,
    parameter int QUEUE_DEPTH   = espp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_byte_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_event_kind,
    output logic [7:0]         o_key_code,
    output logic signed [15:0] o_field_a,
    output logic signed [15:0] o_field_b,
    output logic signed [15:0] o_field_c,
    output logic               o_separation
);
    import espp_pkg::*;

    t_token tok_in, tok_out;
    logic   q_full, q_valid, q_pop;
    t_event evt;

    espp_front u_front (
        .i_byte (i_byte_in),
        .o_tok  (tok_in)
    );

    espp_queue #(
        .WIDTH ($bits(t_token)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (tok_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (tok_out)
    );

    espp_back #(
        .MAX_SEQ_CHARS (MAX_SEQ_CHARS),
        .PARAM_SLOTS   (PARAM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (tok_out),
        .o_tok_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_evt       (evt)
    );

    assign o_in_ready   = !q_full;
    assign o_event_kind = evt.kind;
    assign o_key_code   = evt.key_code;
    assign o_field_a    = evt.field_a;
    assign o_field_b    = evt.field_b;
    assign o_field_c    = evt.field_c;
    assign o_separation = evt.separation;

endmodule

// ----- design/espp_checker.sv -----
module espp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [3:0]         o_event_kind,
    input logic [7:0]         o_key_code,
    input logic signed [15:0] o_field_a,
    input logic signed [15:0] o_field_b,
    input logic signed [15:0] o_field_c,
    input logic               o_separation
);
    import espp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind) &&
            $stable(o_key_code) && $stable(o_field_a))
        else $error("stalled event changed");

    a_key_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == EV_KEY |->
            o_field_a == '0 && o_field_b == '0 && o_field_c == '0 && !o_separation)
        else $error("key event carries parameters");

    a_key_code_only_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EV_KEY |-> o_key_code == '0)
        else $error("key code on non-key event");

    a_sep_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_separation |-> o_event_kind == EV_COLLISION)
        else $error("separation flag outside collision event");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_event_kind <= EV_INVALID)
        else $error("event kind out of range");

endmodule

bind escape_sequence_event_parser_top espp_checker u_espp_checker (.*);
